@@ sv/tcce_pkg.sv @@
// ---------------------------------------------------------------------------
// tcce_pkg: shared definitions for the text console cursor engine
// Screen geometry, cell layout, request and control codes, and the command
// and status words between the controller and the datapath.
// ---------------------------------------------------------------------------
package tcce_pkg;

    // screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLUMNS;
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);

    // field widths
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int ATTR_W   = 8;
    localparam int CHAR_W   = 8;
    localparam int CELL_W   = ATTR_W + CHAR_W;
    localparam int REQ_W    = 2;

    // tab expands into this many blanks
    localparam int TAB_SPACES = 4;
    localparam int PUT_W      = $clog2(TAB_SPACES);

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd7;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] DP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] DP_PUT     = 4'd1;
    localparam logic [OP_W-1:0] DP_NEWLINE = 4'd2;
    localparam logic [OP_W-1:0] DP_RETURN  = 4'd3;
    localparam logic [OP_W-1:0] DP_BACK    = 4'd4;
    localparam logic [OP_W-1:0] DP_SETCUR  = 4'd5;
    localparam logic [OP_W-1:0] DP_CAPTURE = 4'd6;
    localparam logic [OP_W-1:0] DP_FILL    = 4'd7;
    localparam logic [OP_W-1:0] DP_COPY    = 4'd8;

    // sweep counter start points
    localparam logic [1:0] ADDR_ZERO = 2'd0;
    localparam logic [1:0] ADDR_COPY = 2'd1;
    localparam logic [1:0] ADDR_FILL = 2'd2;

    // fill word sources
    localparam logic [1:0] FILL_ZERO    = 2'd0;
    localparam logic [1:0] FILL_CLEAR   = 2'd1;
    localparam logic [1:0] FILL_DEFAULT = 2'd2;

    typedef struct packed {
        logic            latch;
        logic [OP_W-1:0] op;
        logic            addr_load;
        logic [1:0]      addr_sel;
        logic [1:0]      fill_sel;
        logic            set_scr;
        logic            clear_end;
    } tcce_cmd_t;

    typedef struct packed {
        logic at_last_col;
        logic at_last_row;
        logic fill_last;
        logic copy_end;
    } tcce_status_t;

    // linear cell address of a row and column
    function automatic logic [CNT_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        cell_addr = CNT_W'(r) * CNT_W'(COLUMNS) + CNT_W'(c);
    endfunction

endpackage

@@ sv/tcce_ram.sv @@
// ---------------------------------------------------------------------------
// tcce_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/tcce_dpath.sv @@
// ---------------------------------------------------------------------------
// tcce_dpath: console datapath
// Cursor registers, request holding registers, sweep counter for clear and
// scroll, default attribute register and the screen memory.
// ---------------------------------------------------------------------------
module tcce_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcce_pkg::tcce_cmd_t           cmd,
    output tcce_pkg::tcce_status_t        status,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::ATTR_W-1:0]   attr,
    input  logic [tcce_pkg::ROW_W-1:0]    row,
    input  logic [tcce_pkg::COL_W-1:0]    col,
    input  logic                          home_after_clear,
    input  logic                          cfg_we,
    input  logic [tcce_pkg::ATTR_W-1:0]   cfg_data,
    output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    cursor_col,
    output logic [tcce_pkg::CELL_W-1:0]   cell_data,
    output logic                          scrolled
);

    localparam logic [tcce_pkg::ROW_W-1:0] ROW_LAST = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
    localparam logic [tcce_pkg::COL_W-1:0] COL_LAST = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
    localparam logic [tcce_pkg::CNT_W-1:0] CNT_CELLS = tcce_pkg::CNT_W'(tcce_pkg::CELLS);
    localparam logic [tcce_pkg::CNT_W-1:0] CNT_COLS  = tcce_pkg::CNT_W'(tcce_pkg::COLUMNS);

    logic [tcce_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcce_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tcce_pkg::CNT_W-1:0]  addr_reg, addr_next;
    logic [tcce_pkg::ATTR_W-1:0] default_attr_reg;
    logic [tcce_pkg::CHAR_W-1:0] char_reg;
    logic [tcce_pkg::ATTR_W-1:0] attr_reg;
    logic [tcce_pkg::ROW_W-1:0]  tgt_row_reg;
    logic [tcce_pkg::COL_W-1:0]  tgt_col_reg;
    logic                        home_reg;
    logic                        scr_reg;
    logic [tcce_pkg::CELL_W-1:0] cell_reg;

    logic [tcce_pkg::ROW_W-1:0]  row_sat;
    logic [tcce_pkg::COL_W-1:0]  col_sat;
    logic [tcce_pkg::ROW_W-1:0]  bk_row;
    logic [tcce_pkg::COL_W-1:0]  bk_col;
    logic [tcce_pkg::ATTR_W-1:0] clear_attr;
    logic [tcce_pkg::CELL_W-1:0] fill_word;
    logic [tcce_pkg::CNT_W-1:0]  waddr_full;
    logic [tcce_pkg::CNT_W-1:0]  raddr_full;
    logic                        we;
    logic                        re;
    logic [tcce_pkg::CELL_W-1:0] wdata;
    logic [tcce_pkg::CELL_W-1:0] rdata;

    // saturate the request target to the screen
    assign row_sat = (row > ROW_LAST) ? ROW_LAST : row;
    assign col_sat = (col > COL_LAST) ? COL_LAST : col;

    // cursor one cell back, held at the top left corner
    always_comb
    begin
        bk_row = cur_row_reg;
        bk_col = cur_col_reg - 1'b1;
        if (cur_col_reg == '0)
        begin
            if (cur_row_reg == '0)
            begin
                bk_col = '0;
            end
            else
            begin
                bk_row = cur_row_reg - 1'b1;
                bk_col = COL_LAST;
            end
        end
    end

    // blank word for sweeps
    assign clear_attr = (attr_reg != '0) ? attr_reg : default_attr_reg;

    always_comb
    begin
        case (cmd.fill_sel)
            tcce_pkg::FILL_ZERO:    fill_word = '0;
            tcce_pkg::FILL_CLEAR:   fill_word = {clear_attr, tcce_pkg::CH_BLANK};
            tcce_pkg::FILL_DEFAULT: fill_word = {default_attr_reg, tcce_pkg::CH_BLANK};
            default:                fill_word = '0;
        endcase
    end

    // memory write port
    always_comb
    begin
        we         = 1'b0;
        waddr_full = addr_reg;
        wdata      = fill_word;
        case (cmd.op)
            tcce_pkg::DP_PUT:
            begin
                we         = 1'b1;
                waddr_full = tcce_pkg::cell_addr(cur_row_reg, cur_col_reg);
                wdata      = {attr_reg, char_reg};
            end
            tcce_pkg::DP_BACK:
            begin
                we         = 1'b1;
                waddr_full = tcce_pkg::cell_addr(bk_row, bk_col);
                wdata      = {attr_reg, tcce_pkg::CH_BLANK};
            end
            tcce_pkg::DP_FILL:
            begin
                we         = 1'b1;
                waddr_full = addr_reg;
                wdata      = fill_word;
            end
            tcce_pkg::DP_COPY:
            begin
                // registered read word lands one row up
                we         = (addr_reg > CNT_COLS);
                waddr_full = addr_reg - CNT_COLS - 1'b1;
                wdata      = rdata;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // memory read port: sweep source while scrolling, request target otherwise
    always_comb
    begin
        if (cmd.op == tcce_pkg::DP_COPY)
        begin
            re         = (addr_reg < CNT_CELLS);
            raddr_full = addr_reg;
        end
        else
        begin
            re         = 1'b1;
            raddr_full = tcce_pkg::cell_addr(row_sat, col_sat);
        end
    end

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[tcce_pkg::CELL_AW-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_full[tcce_pkg::CELL_AW-1:0]),
        .rdata (rdata)
    );

    // cursor update
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        case (cmd.op)
            tcce_pkg::DP_PUT:
            begin
                if (cur_col_reg >= COL_LAST)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg < ROW_LAST)
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
            tcce_pkg::DP_NEWLINE:
            begin
                cur_col_next = '0;
                if (cur_row_reg < ROW_LAST)
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            tcce_pkg::DP_RETURN:
            begin
                cur_col_next = '0;
            end
            tcce_pkg::DP_BACK:
            begin
                cur_row_next = bk_row;
                cur_col_next = bk_col;
            end
            tcce_pkg::DP_SETCUR:
            begin
                cur_row_next = tgt_row_reg;
                cur_col_next = tgt_col_reg;
            end
            default:
            begin
                cur_row_next = cur_row_reg;
            end
        endcase
        if (cmd.clear_end && home_reg)
        begin
            cur_row_next = '0;
            cur_col_next = '0;
        end
    end

    // sweep counter
    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.addr_load)
        begin
            case (cmd.addr_sel)
                tcce_pkg::ADDR_ZERO: addr_next = '0;
                tcce_pkg::ADDR_COPY: addr_next = CNT_COLS;
                tcce_pkg::ADDR_FILL:
                    addr_next = tcce_pkg::CNT_W'((tcce_pkg::ROWS - 1) * tcce_pkg::COLUMNS);
                default:             addr_next = '0;
            endcase
        end
        else if (cmd.op == tcce_pkg::DP_FILL || cmd.op == tcce_pkg::DP_COPY)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            addr_reg         <= '0;
            default_attr_reg <= tcce_pkg::DEFAULT_ATTR_RST;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            addr_reg    <= addr_next;
            if (cfg_we)
            begin
                default_attr_reg <= cfg_data;
            end
        end
    end

    // request holding and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            char_reg    <= (char_code == tcce_pkg::CH_TAB) ? tcce_pkg::CH_BLANK : char_code;
            attr_reg    <= attr;
            tgt_row_reg <= row_sat;
            tgt_col_reg <= col_sat;
            home_reg    <= home_after_clear;
            scr_reg     <= 1'b0;
            cell_reg    <= '0;
        end
        else
        begin
            if (cmd.set_scr)
            begin
                scr_reg <= 1'b1;
            end
            if (cmd.op == tcce_pkg::DP_CAPTURE)
            begin
                cell_reg <= rdata;
            end
        end
    end

    // status to the controller
    assign status.at_last_col = (cur_col_reg >= COL_LAST);
    assign status.at_last_row = (cur_row_reg >= ROW_LAST);
    assign status.fill_last   = (addr_reg == CNT_CELLS - 1'b1);
    assign status.copy_end    = (addr_reg == CNT_CELLS);

    assign cursor_row = cur_row_reg;
    assign cursor_col = cur_col_reg;
    assign cell_data  = cell_reg;
    assign scrolled   = scr_reg;

endmodule

@@ sv/tcce_ctrl.sv @@
// ---------------------------------------------------------------------------
// tcce_ctrl: console controller
// Request decode and sequencing of puts, tabs, scrolls, clears and the
// clearing pass after reset.
// ---------------------------------------------------------------------------
module tcce_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcce_pkg::REQ_W-1:0]    req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  tcce_pkg::tcce_status_t        status,
    output tcce_pkg::tcce_cmd_t           cmd,
    output logic                          busy,
    output logic                          done
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_INIT  = 4'd0;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd1;
    localparam logic [ST_W-1:0] S_PUT   = 4'd2;
    localparam logic [ST_W-1:0] S_NL    = 4'd3;
    localparam logic [ST_W-1:0] S_CR    = 4'd4;
    localparam logic [ST_W-1:0] S_BS    = 4'd5;
    localparam logic [ST_W-1:0] S_CLEAR = 4'd6;
    localparam logic [ST_W-1:0] S_SET   = 4'd7;
    localparam logic [ST_W-1:0] S_READ  = 4'd8;
    localparam logic [ST_W-1:0] S_SCOPY = 4'd9;
    localparam logic [ST_W-1:0] S_SFILL = 4'd10;

    logic [ST_W-1:0]            state_reg, state_next;
    logic [tcce_pkg::PUT_W-1:0] put_left_reg, put_left_next;
    logic                       done_reg, done_next;

    // next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        put_left_next = put_left_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.op        = tcce_pkg::DP_NOP;
        case (state_reg)
            S_INIT:
            begin
                cmd.op       = tcce_pkg::DP_FILL;
                cmd.fill_sel = tcce_pkg::FILL_ZERO;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch     = 1'b1;
                    put_left_next = '0;
                    case (req_type)
                        tcce_pkg::REQ_PUT:
                        begin
                            case (char_code)
                                tcce_pkg::CH_NEWLINE:   state_next = S_NL;
                                tcce_pkg::CH_RETURN:    state_next = S_CR;
                                tcce_pkg::CH_BACKSPACE: state_next = S_BS;
                                tcce_pkg::CH_TAB:
                                begin
                                    put_left_next = tcce_pkg::PUT_W'(tcce_pkg::TAB_SPACES - 1);
                                    state_next    = S_PUT;
                                end
                                default:                state_next = S_PUT;
                            endcase
                        end
                        tcce_pkg::REQ_CLEAR:
                        begin
                            cmd.addr_load = 1'b1;
                            cmd.addr_sel  = tcce_pkg::ADDR_ZERO;
                            state_next    = S_CLEAR;
                        end
                        tcce_pkg::REQ_SET:  state_next = S_SET;
                        tcce_pkg::REQ_READ: state_next = S_READ;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_PUT:
            begin
                cmd.op = tcce_pkg::DP_PUT;
                if (status.at_last_col && status.at_last_row)
                begin
                    cmd.set_scr   = 1'b1;
                    cmd.addr_load = 1'b1;
                    cmd.addr_sel  = tcce_pkg::ADDR_COPY;
                    state_next    = S_SCOPY;
                end
                else if (put_left_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    put_left_next = put_left_reg - 1'b1;
                end
            end
            S_NL:
            begin
                cmd.op = tcce_pkg::DP_NEWLINE;
                if (status.at_last_row)
                begin
                    cmd.set_scr   = 1'b1;
                    cmd.addr_load = 1'b1;
                    cmd.addr_sel  = tcce_pkg::ADDR_COPY;
                    state_next    = S_SCOPY;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCOPY:
            begin
                cmd.op = tcce_pkg::DP_COPY;
                if (status.copy_end)
                begin
                    cmd.addr_load = 1'b1;
                    cmd.addr_sel  = tcce_pkg::ADDR_FILL;
                    state_next    = S_SFILL;
                end
            end
            S_SFILL:
            begin
                cmd.op       = tcce_pkg::DP_FILL;
                cmd.fill_sel = tcce_pkg::FILL_DEFAULT;
                if (status.fill_last)
                begin
                    if (put_left_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        put_left_next = put_left_reg - 1'b1;
                        state_next    = S_PUT;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.op       = tcce_pkg::DP_FILL;
                cmd.fill_sel = tcce_pkg::FILL_CLEAR;
                if (status.fill_last)
                begin
                    cmd.clear_end = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CR:
            begin
                cmd.op     = tcce_pkg::DP_RETURN;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_BS:
            begin
                cmd.op     = tcce_pkg::DP_BACK;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SET:
            begin
                cmd.op     = tcce_pkg::DP_SETCUR;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.op     = tcce_pkg::DP_CAPTURE;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            put_left_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            put_left_reg <= put_left_next;
            done_reg     <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // result strobe only shows while the controller is idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // an accepted word always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start work");

    // one strobe per word
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // pending tab blanks only while putting or scrolling
    a_put_left: assert property (@(posedge clk) disable iff (!rst_n)
        (put_left_reg != '0) |->
            (state_reg == S_PUT || state_reg == S_SCOPY || state_reg == S_SFILL))
        else $error("tab blanks pending outside put sequence");

endmodule

@@ sv/text_console_cursor_engine_unit.sv @@
// ---------------------------------------------------------------------------
// text_console_cursor_engine_unit: character-cell text console
// Screen store of attribute and character cells with a cursor, taking
// put-character, clear, set-cursor and read-cell requests.
// ---------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; its result is
// shown for one cycle with done high and must be taken then, since the
// receiver cannot hold it off. A new word can be taken in that same cycle.
// A tab puts TAB_SPACES blanks. A scroll walks the screen memory, which has a
// separate read and write port, one cell per cycle: it copies each row one row
// up and then fills the last row with blanks in the default attribute, before
// the request that causes it finishes. After reset the screen memory is swept
// to zero with busy high; configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module text_console_cursor_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tcce_pkg::REQ_W-1:0]    req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::ATTR_W-1:0]   attr,
    input  logic [tcce_pkg::ROW_W-1:0]    row,
    input  logic [tcce_pkg::COL_W-1:0]    col,
    input  logic                          home_after_clear,
    output logic                          done,
    output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    cursor_col,
    output logic [tcce_pkg::CELL_W-1:0]   cell_data,
    output logic                          scrolled,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0]   cfg_data
);

    tcce_pkg::tcce_cmd_t    cmd;
    tcce_pkg::tcce_status_t status;

    // configuration word always taken
    assign cfg_ready = 1'b1;

    // sequencing
    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .char_code (char_code),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // cursor, screen memory and result registers
    tcce_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .char_code        (char_code),
        .attr             (attr),
        .row              (row),
        .col              (col),
        .home_after_clear (home_after_clear),
        .cfg_we           (cfg_valid & cfg_ready),
        .cfg_data         (cfg_data),
        .cursor_row       (cursor_row),
        .cursor_col       (cursor_col),
        .cell_data        (cell_data),
        .scrolled         (scrolled)
    );

endmodule
